### rtl/hpq_pkg.sv
// Shared types and constants for the binary max-heap priority queue.
// No dependencies; every other file in rtl/ imports this package.
package hpq_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned CntOutW = 9;

  // Command codes carried on cmd_i.
  localparam logic [CmdW-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CmdW-1:0] CMD_POP   = 2'd1;
  localparam logic [CmdW-1:0] CMD_CLEAR = 2'd2;

  typedef logic [DataW-1:0] key_t;

endpackage

### rtl/hpq_ram.sv
// Heap store: single write port, single read port with registered read data.
// Depends on hpq_pkg for the key type.
module hpq_ram
  import hpq_pkg::*;
#(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  key_t             wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output key_t             rdata_o
);

  key_t mem_q [Depth];
  key_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/hpq_cmp.sv
// Shared unsigned key comparator used by every sift step.
// Depends on hpq_pkg for the key type.
module hpq_cmp
  import hpq_pkg::*;
(
  input  key_t a_i,
  input  key_t b_i,
  output logic gt_o
);

  // Strictly greater: equal keys never move.
  assign gt_o = (a_i > b_i);

endmodule

### rtl/binary_max_heap_priority_queue_top.sv
// Top level of the binary max-heap priority queue: sift sequencer and registers.
// Depends on hpq_pkg, hpq_ram and hpq_cmp.
//
//   Port group          Direction  Handshake
//   start/cmd/value     in         beat taken when start is high and busy is low
//   done/ok/top/count   out        beat shown for one cycle while done_o is high
//
// A push walks the new key up level by level: each level reads the parent and then
// compares and writes, and the walk ends when the key reaches the root or meets a
// parent that is not smaller. A pop fetches the last entry as the new root, then
// walks it down level by level: each level reads the left child, reads the right
// child if there is one, compares, and writes; reaching a leaf adds a final write
// of the moved key. A pop that leaves a single entry writes the fetched entry
// straight to the root. The stepwise walk is set by the single read port of the
// heap store and the one shared comparator. Clear, a failing command and a pop
// that empties the queue finish straight from idle. Reset empties the queue at
// once; the store itself is never cleared, since only entries below the count are
// ever read. The receiver cannot stall results.
module binary_max_heap_priority_queue_top
  import hpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [CmdW-1:0]    cmd_i,
  input  key_t               value_i,
  output logic               done_o,
  output logic               ok_o,
  output key_t               top_value_o,
  output logic               top_valid_o,
  output logic [CntOutW-1:0] entry_count_o
);

  // Index width covers positions 0..CAPACITY-1; the count also holds CAPACITY.
  // Child indices carry two bits more than a position index so 2*pos+2 never wraps.
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned ChW  = IdxW + 2;

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP_RD  = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_DN_LD  = 3'd3;
  localparam logic [2:0] S_DN_L   = 3'd4;
  localparam logic [2:0] S_DN_R   = 3'd5;
  localparam logic [2:0] S_DN_CMP = 3'd6;
  localparam logic [2:0] S_WR     = 3'd7;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [IdxW-1:0] cidx_q, cidx_d;
  key_t            hold_q, hold_d;
  key_t            cand_q, cand_d;
  key_t            top_q, top_d;
  logic            ok_q, ok_d;
  logic            done_q, done_d;

  // Heap store ports.
  logic            we;
  logic [IdxW-1:0] waddr;
  key_t            wdata;
  logic [IdxW-1:0] raddr;
  key_t            rdata;

  // Shared comparator ports.
  key_t cmp_a;
  key_t cmp_b;
  logic cmp_gt;

  logic [ChW-1:0]  cnt_ext;
  logic [ChW-1:0]  lc_pos;
  logic [ChW-1:0]  rc_pos;
  logic [ChW-1:0]  lc_cand;
  logic [IdxW-1:0] parent;
  logic [31:0]     cnt_wide;

  hpq_ram #(
    .Depth (CAPACITY),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  hpq_cmp u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .gt_o (cmp_gt)
  );

  // Heap index arithmetic: children at 2p+1 and 2p+2, parent at (p-1)/2.
  assign cnt_ext = ChW'(count_q);
  assign lc_pos  = {1'b0, pos_q, 1'b1};
  assign rc_pos  = lc_pos + ChW'(1);
  assign lc_cand = {1'b0, cidx_q, 1'b1};
  assign parent  = (pos_q - IdxW'(1)) >> 1;

  // The comparator operands follow the step being taken.
  always_comb begin
    unique case (state_q)
      S_UP_CMP: begin
        cmp_a = hold_q;
        cmp_b = rdata;
      end
      S_DN_R: begin
        cmp_a = rdata;
        cmp_b = cand_q;
      end
      default: begin
        cmp_a = cand_q;
        cmp_b = hold_q;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    pos_d   = pos_q;
    cidx_d  = cidx_q;
    hold_d  = hold_q;
    cand_d  = cand_q;
    ok_d    = ok_q;
    done_d  = 1'b0;
    we      = 1'b0;
    waddr   = pos_q;
    wdata   = hold_q;
    raddr   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_i)
            CMD_PUSH: begin
              if (count_q < CntW'(CAPACITY)) begin
                ok_d    = 1'b1;
                count_d = count_q + CntW'(1);
                hold_d  = value_i;
                pos_d   = IdxW'(count_q);
                state_d = S_UP_RD;
              end else begin
                ok_d   = 1'b0;
                done_d = 1'b1;
              end
            end
            CMD_POP: begin
              if (count_q != '0) begin
                ok_d    = 1'b1;
                count_d = count_q - CntW'(1);
                if (count_q == CntW'(1)) begin
                  done_d = 1'b1;
                end else begin
                  // Fetch the last entry; it becomes the new root.
                  raddr   = IdxW'(count_q - CntW'(1));
                  state_d = S_DN_LD;
                end
              end else begin
                ok_d   = 1'b0;
                done_d = 1'b1;
              end
            end
            CMD_CLEAR: begin
              ok_d    = 1'b1;
              count_d = '0;
              done_d  = 1'b1;
            end
            default: begin
              ok_d   = 1'b0;
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_UP_RD: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = S_IDLE;
          done_d  = 1'b1;
        end else begin
          raddr   = parent;
          state_d = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        we = 1'b1;
        if (cmp_gt) begin
          // Parent is smaller: move it down into the hole and climb.
          wdata   = rdata;
          pos_d   = parent;
          state_d = S_UP_RD;
        end else begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end

      S_DN_LD: begin
        hold_d = rdata;
        pos_d  = '0;
        if (cnt_ext > ChW'(1)) begin
          raddr   = IdxW'(1);
          state_d = S_DN_L;
        end else begin
          we      = 1'b1;
          waddr   = '0;
          wdata   = rdata;
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end

      S_DN_L: begin
        cand_d = rdata;
        cidx_d = IdxW'(lc_pos);
        if (rc_pos < cnt_ext) begin
          raddr   = IdxW'(rc_pos);
          state_d = S_DN_R;
        end else begin
          state_d = S_DN_CMP;
        end
      end

      S_DN_R: begin
        // The right child wins only when strictly larger than the left.
        if (cmp_gt) begin
          cand_d = rdata;
          cidx_d = IdxW'(rc_pos);
        end
        state_d = S_DN_CMP;
      end

      S_DN_CMP: begin
        we = 1'b1;
        if (cmp_gt) begin
          wdata = cand_q;
          pos_d = cidx_q;
          if (lc_cand < cnt_ext) begin
            raddr   = IdxW'(lc_cand);
            state_d = S_DN_L;
          end else begin
            state_d = S_WR;
          end
        end else begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end

      S_WR: begin
        we      = 1'b1;
        state_d = S_IDLE;
        done_d  = 1'b1;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The root is mirrored in a register so the maximum is at hand whenever idle.
  assign top_d = (we && (waddr == '0)) ? wdata : top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ok_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ok_q    <= ok_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    cidx_q <= cidx_d;
    hold_q <= hold_d;
    cand_q <= cand_d;
    top_q  <= top_d;
  end

  assign cnt_wide = 32'(count_q);

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign ok_o          = ok_q;
  assign top_valid_o   = (count_q != '0);
  assign top_value_o   = (count_q != '0) ? top_q : '0;
  assign entry_count_o = cnt_wide[CntOutW-1:0];

endmodule
